FILE: hdl/nmea_sentence_framer_checker_defines.svh
// Assertion helpers, all clocked on i_clk and disabled in reset.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define NSFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nsfc port check failed");

// Next-cycle implication.
`define NSFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nsfc port check failed");

`endif

FILE: hdl/nsfc_pkg.sv
package nsfc_pkg;

    localparam int MaxSentenceLen = 128;
    localparam int CountW         = 8;
    localparam int MinSentenceLen = 10;

    localparam logic [7:0] CharDollar = 8'h24;
    localparam logic [7:0] CharStar   = 8'h2A;
    localparam logic [7:0] CharCr     = 8'h0D;

    localparam logic [23:0] TypeRmb = 24'h524D42;
    localparam logic [23:0] TypeRmc = 24'h524D43;
    localparam logic [23:0] TypeGga = 24'h474741;
    localparam logic [23:0] TypeVtg = 24'h565447;
    localparam logic [23:0] TypeMwv = 24'h4D5756;
    localparam logic [23:0] TypeDpt = 24'h445054;
    localparam logic [23:0] TypeVhw = 24'h564857;
    localparam logic [23:0] TypeHdg = 24'h484447;

    localparam logic [3:0] KindUnknown = 4'd0;
    localparam logic [3:0] KindRmb     = 4'd1;
    localparam logic [3:0] KindRmc     = 4'd2;
    localparam logic [3:0] KindGga     = 4'd3;
    localparam logic [3:0] KindVtg     = 4'd4;
    localparam logic [3:0] KindMwv     = 4'd5;
    localparam logic [3:0] KindDpt     = 4'd6;
    localparam logic [3:0] KindVhw     = 4'd7;
    localparam logic [3:0] KindHdg     = 4'd8;

    localparam logic [2:0] OutAccepted   = 3'd0;
    localparam logic [2:0] OutWrongLink  = 3'd1;
    localparam logic [2:0] OutUnknown    = 3'd2;
    localparam logic [2:0] OutBadSum     = 3'd3;
    localparam logic [2:0] OutBadLength  = 3'd4;

    localparam logic [2:0] CfgNav     = 3'd0;
    localparam logic [2:0] CfgGnss    = 3'd1;
    localparam logic [2:0] CfgWind    = 3'd2;
    localparam logic [2:0] CfgDepth   = 3'd3;
    localparam logic [2:0] CfgSpeed   = 3'd4;
    localparam logic [2:0] CfgCompass = 3'd5;

    typedef struct packed {
        logic              active;
        logic [CountW-1:0] count;
        logic [7:0]        running_xor;
        logic [7:0]        star_xor;
        logic              star_seen;
        logic              sum_ok;
        logic [23:0]       type_chars;
    } t_link_view;

    function automatic logic [3:0] kind_of(input logic [23:0] t);
        logic [3:0] k;
        case (t)
            TypeRmb: k = KindRmb;
            TypeRmc: k = KindRmc;
            TypeGga: k = KindGga;
            TypeVtg: k = KindVtg;
            TypeMwv: k = KindMwv;
            TypeDpt: k = KindDpt;
            TypeVhw: k = KindVhw;
            TypeHdg: k = KindHdg;
            default: k = KindUnknown;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/nmea_sentence_framer_checker.sv
// channel   dir  handshake                    payload
// in        in   i_in_valid / o_in_stall      i_rx_byte, i_link_id
// out       out  o_out_valid / i_out_stall    o_outcome .. o_sentence_length
// cfg       in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while o_in_stall is low; a result follows its CR request
// through the input register, then from the selected per-link context into the result register.
// Synchronous active-low reset clears all framing contexts and loads source defaults.
// A stalled result holds the result register; the input register stalls only while
// the result register is full and stalled.
module nmea_sentence_framer_checker #(
    parameter int MAX_SENTENCE_LEN = nsfc_pkg::MaxSentenceLen
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic [1:0] i_link_id,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_outcome,
    output logic [3:0] o_sentence_kind,
    output logic       o_from_link,
    output logic       o_forward_external,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_sentence_length,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [1:0] i_cfg_data
);
    import nsfc_pkg::*;

    logic [1:0] r_src [6];

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [1:0] r_in_link;

    logic       advance;
    logic       step;
    logic [1:0] link_en;
    t_link_view view [2];
    t_link_view sel;
    logic       produce;

    logic [2:0] n_outcome;
    logic [3:0] n_kind;
    logic [3:0] kind_raw;
    logic [1:0] src;
    logic       n_fwd;
    logic       len_bad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src[CfgNav]     <= 2'd0;
            r_src[CfgGnss]    <= 2'd1;
            r_src[CfgWind]    <= 2'd2;
            r_src[CfgDepth]   <= 2'd2;
            r_src[CfgSpeed]   <= 2'd2;
            r_src[CfgCompass] <= 2'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgNav:     r_src[CfgNav]     <= i_cfg_data;
                CfgGnss:    r_src[CfgGnss]    <= i_cfg_data;
                CfgWind:    r_src[CfgWind]    <= i_cfg_data;
                CfgDepth:   r_src[CfgDepth]   <= i_cfg_data;
                CfgSpeed:   r_src[CfgSpeed]   <= i_cfg_data;
                CfgCompass: r_src[CfgCompass] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
            r_in_link <= i_link_id;
        end
    end

    assign step       = r_in_valid && advance && !r_in_link[1];
    assign link_en[0] = step && !r_in_link[0];
    assign link_en[1] = step && r_in_link[0];

    for (genvar g = 0; g < 2; g++) begin : g_link
        nsfc_link #(
            .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
        ) u_link (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (link_en[g]),
            .i_byte (r_in_byte),
            .o_view (view[g])
        );
    end

    assign sel     = r_in_link[0] ? view[1] : view[0];
    assign produce = step && sel.active && (r_in_byte == CharCr);

    assign kind_raw = kind_of(sel.type_chars);
    assign len_bad  = (sel.count < CountW'(MinSentenceLen))
                   || ({1'b0, sel.count} >= (CountW+1)'(MAX_SENTENCE_LEN - 1));

    always_comb begin
        case (kind_raw)
            KindRmb:                   src = r_src[CfgNav];
            KindRmc, KindGga, KindVtg: src = r_src[CfgGnss];
            KindMwv:                   src = r_src[CfgWind];
            KindDpt:                   src = r_src[CfgDepth];
            KindVhw:                   src = r_src[CfgSpeed];
            default:                   src = r_src[CfgCompass];
        endcase
    end

    always_comb begin
        n_kind = KindUnknown;
        n_fwd  = 1'b0;
        if (len_bad) begin
            n_outcome = OutBadLength;
        end else if (!sel.sum_ok) begin
            n_outcome = OutBadSum;
        end else begin
            n_kind = kind_raw;
            if (kind_raw == KindUnknown) begin
                n_outcome = OutUnknown;
            end else if (r_in_link != src) begin
                n_outcome = OutWrongLink;
            end else begin
                n_outcome = OutAccepted;
                n_fwd = r_in_link[0]
                     && (kind_raw == KindRmc || kind_raw == KindGga || kind_raw == KindVtg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance) begin
            o_out_valid <= produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            o_outcome           <= n_outcome;
            o_sentence_kind     <= n_kind;
            o_from_link         <= r_in_link[0];
            o_forward_external  <= n_fwd;
            o_computed_checksum <= sel.star_seen ? sel.star_xor : sel.running_xor;
            o_sentence_length   <= sel.count;
        end
    end

endmodule

FILE: hdl/nsfc_link.sv
module nsfc_link #(
    parameter int MAX_SENTENCE_LEN = nsfc_pkg::MaxSentenceLen
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    output nsfc_pkg::t_link_view o_view
);
    import nsfc_pkg::*;

    logic              r_active,   n_active;
    logic [CountW-1:0] r_count,    n_count;
    logic [7:0]        r_run_xor,  n_run_xor;
    logic [7:0]        r_star_xor, n_star_xor;
    logic              r_star,     n_star;
    logic [1:0]        r_taken,    n_taken;
    logic [7:0]        r_rcv,      n_rcv;
    logic              r_hex_ok,   n_hex_ok;
    logic [23:0]       r_type,     n_type;

    logic [CountW:0]   count_inc;
    logic [4:0]        nib;

    // {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else                               r = 5'd0;
        return r;
    endfunction

    assign count_inc = {1'b0, r_count} + {{CountW{1'b0}}, 1'b1};
    assign nib       = hex_nibble(i_byte);

    always_comb begin
        n_active   = r_active;
        n_count    = r_count;
        n_run_xor  = r_run_xor;
        n_star_xor = r_star_xor;
        n_star     = r_star;
        n_taken    = r_taken;
        n_rcv      = r_rcv;
        n_hex_ok   = r_hex_ok;
        n_type     = r_type;
        if (i_en && (i_byte == CharDollar || (r_active && i_byte == CharCr))) begin
            n_active   = (i_byte == CharDollar);
            n_count    = (i_byte == CharDollar) ? CountW'(1) : '0;
            n_run_xor  = '0;
            n_star_xor = '0;
            n_star     = 1'b0;
            n_taken    = '0;
            n_rcv      = '0;
            n_hex_ok   = 1'b1;
            n_type     = '0;
        end else if (i_en && r_active) begin
            if (i_byte == CharStar) begin
                n_star_xor = r_run_xor;
                n_star     = 1'b1;
                n_taken    = '0;
                n_rcv      = '0;
                n_hex_ok   = 1'b1;
            end else if (r_star && r_taken != 2'd2) begin
                if (!nib[4]) n_hex_ok = 1'b0;
                else         n_rcv    = {r_rcv[3:0], nib[3:0]};
                n_taken = r_taken + 2'd1;
            end
            n_run_xor = r_run_xor ^ i_byte;
            if (r_count >= CountW'(3) && r_count <= CountW'(5)) begin
                n_type = {r_type[15:0], i_byte};
            end
            if (count_inc >= (CountW+1)'(MAX_SENTENCE_LEN)) begin
                n_active   = 1'b0;
                n_count    = '0;
                n_run_xor  = '0;
                n_star_xor = '0;
                n_star     = 1'b0;
                n_taken    = '0;
                n_rcv      = '0;
                n_hex_ok   = 1'b1;
                n_type     = '0;
            end else begin
                n_count = count_inc[CountW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_count    <= '0;
            r_run_xor  <= '0;
            r_star_xor <= '0;
            r_star     <= 1'b0;
            r_taken    <= '0;
            r_rcv      <= '0;
            r_hex_ok   <= 1'b1;
            r_type     <= '0;
        end else begin
            r_active   <= n_active;
            r_count    <= n_count;
            r_run_xor  <= n_run_xor;
            r_star_xor <= n_star_xor;
            r_star     <= n_star;
            r_taken    <= n_taken;
            r_rcv      <= n_rcv;
            r_hex_ok   <= n_hex_ok;
            r_type     <= n_type;
        end
    end

    always_comb begin
        o_view.active      = r_active;
        o_view.count       = r_count;
        o_view.running_xor = r_run_xor;
        o_view.star_xor    = r_star_xor;
        o_view.star_seen   = r_star;
        o_view.sum_ok      = r_star && (r_taken == 2'd2) && r_hex_ok && (r_rcv == r_star_xor);
        o_view.type_chars  = r_type;
    end

endmodule

FILE: hdl/nsfc_checker.sv
`include "nmea_sentence_framer_checker_defines.svh"

module nsfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_outcome,
    input logic [3:0] o_sentence_kind,
    input logic       o_from_link,
    input logic       o_forward_external,
    input logic [7:0] o_sentence_length
);
    import nsfc_pkg::*;

    logic early_fail;
    logic accepted_gnss;
    logic len_ok;

    assign early_fail    = (o_outcome == OutBadSum) || (o_outcome == OutBadLength);
    assign accepted_gnss = (o_outcome == OutAccepted) && o_from_link;
    assign len_ok        = o_sentence_length >= 8'(MinSentenceLen);

    `NSFC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `NSFC_ASSERT_NOW(a_kind_on_fail, o_out_valid && early_fail, o_sentence_kind == KindUnknown)
    `NSFC_ASSERT_NOW(a_fwd_gnss, o_out_valid && o_forward_external, accepted_gnss)
    `NSFC_ASSERT_NOW(a_len_window, o_out_valid && o_outcome != OutBadLength, len_ok)

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (.*);
